[hdl/piecewise_linear_temp_calibrator_macros.svh]
// Assertion macros for the piecewise linear temperature calibrator.
`ifndef PIECEWISE_LINEAR_TEMP_CALIBRATOR_MACROS_SVH
`define PIECEWISE_LINEAR_TEMP_CALIBRATOR_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define PLC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plc assertion failed");
// next-cycle implication
`define PLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plc assertion failed");
`else
`define PLC_ASSERT_NOW(lbl, ante, cons)
`define PLC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hdl/plc_pkg.sv]
// Shared types and constants of the temperature calibrator.
package plc_pkg;

  localparam int TEMP_W   = 16;
  localparam int DIFF_W   = 17;
  localparam int PROD_W   = 34;
  localparam int DIVN_W   = 32;
  localparam int DIVD_W   = 16;
  localparam int SUM_W    = 35;
  localparam int SENSOR_W = 2;
  localparam int POINT_W  = 3;
  localparam int WORD_W   = 2 * TEMP_W;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  localparam int SENSOR_LSB = 0;
  localparam int POINT_LSB  = 2;
  localparam int REF_LSB    = 5;
  localparam int OFF_LSB    = 21;
  localparam int RAW_LSB    = 37;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_FLAT = 2'd2
  } status_t;

  typedef enum logic {
    FN_LOAD = 1'b0,
    FN_CAL  = 1'b1
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADDR,
    S_CMP,
    S_RDB,
    S_RDT,
    S_DIFF,
    S_MUL,
    S_START,
    S_DIV,
    S_FIN
  } state_t;

endpackage

[hdl/plc_table.sv]
// Breakpoint memory: one write port, one registered read port.
module plc_table #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [plc_pkg::WORD_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic [plc_pkg::WORD_W-1:0] rd_data
);
  import plc_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/plc_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module plc_divider #(
  parameter int NW = 32,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] numer,
  input  logic [DW-1:0] denom,
  output logic [NW-1:0] quot,
  output logic          done
);
  import plc_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] den;
  logic [NW-1:0] qr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          qbit;

  always_comb begin
    trial = {rem, qr[NW-1]};
    diff  = trial - {1'b0, den};
    qbit  = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qr  <= numer;
      rem <= '0;
      den <= denom;
    end else if (busy) begin
      qr  <= {qr[NW-2:0], qbit};
      rem <= qbit ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign quot = qr;

endmodule

[hdl/piecewise_linear_temp_calibrator.sv]
// Top level: per-sensor piecewise linear temperature calibrator.
//
// Input stream s_*: one word per item. s_tuser selects load (0) or calibrate (1).
// A load word writes one breakpoint and gives no result.
// A calibrate word gives one result word on m_*; status rides in m_tuser.
// s_tready is high only while the sequencer is idle.
// A calibrate word first scans the breakpoints (1..POINTS of them) on the single
// table read port, an address and a compare step per breakpoint, then reads the
// two segment ends, forms the differences, multiplies, starts the serial divider
// (one quotient bit per cycle), waits for its done, and ends in the final step.
// A flat segment skips the divider.
// One load per cycle while idle; a calibrate is taken only after the last one ends.
// The result sits in an output register; the next word is accepted while it
// waits. If the receiver stalls with a result still pending, a following
// calibrate holds its result in the final step until the register frees.
// Reset (rst, synchronous) clears the sequencer and the output valid; the
// breakpoint memory is not cleared and must be loaded before use.
module piecewise_linear_temp_calibrator #(
  parameter int POINTS  = 8,
  parameter int SENSORS = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // sensor[1:0], point[4:2], ref_temp[20:5], point_offset[36:21], raw_temp[52:37]
  input  logic [plc_pkg::IN_DATA_W-1:0]  s_tdata,
  // func
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // calibrated_temp[15:0], sensor_echo[17:16]
  output logic [plc_pkg::OUT_DATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [1:0]                     m_tuser
);
  import plc_pkg::*;

  `include "piecewise_linear_temp_calibrator_macros.svh"

  localparam int DEPTH = SENSORS * POINTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(POINTS);

  state_t state, state_next;

  logic [SENSOR_W-1:0] in_sensor;
  logic [POINT_W-1:0]  in_point;
  temp_t               in_ref, in_off, in_raw;
  int                  in_wrap;
  logic [AW-1:0]       in_base;
  diff_t               load_diff;
  temp_t               load_meas;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;

  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;
  temp_t             rd_meas, rd_off;

  logic [IW-1:0]       idx, top;
  logic [AW-1:0]       base;
  temp_t               raw, mb, ob;
  logic [SENSOR_W-1:0] sens;
  diff_t               dm, dof, dr;
  logic signed [PROD_W-1:0] num;
  logic                flat, neg;

  logic              div_start, div_done;
  logic [DIVN_W-1:0] div_numer, div_quot;
  logic [DIVD_W-1:0] div_denom;
  logic [PROD_W-1:0] num_mag;
  diff_t             dm_mag;

  logic signed [SUM_W-1:0] q_s, sum;
  temp_t                   cal_val;
  status_t                 cal_status;
  logic                    out_free, out_load, found;

  logic [TEMP_W-1:0]   out_cal;
  logic [SENSOR_W-1:0] out_sens;
  status_t             out_status;

  assign in_sensor = s_tdata[SENSOR_LSB +: SENSOR_W];
  assign in_point  = s_tdata[POINT_LSB +: POINT_W];
  assign in_ref    = s_tdata[REF_LSB +: TEMP_W];
  assign in_off    = s_tdata[OFF_LSB +: TEMP_W];
  assign in_raw    = s_tdata[RAW_LSB +: TEMP_W];

  // sensor index wraps modulo SENSORS
  always_comb begin
    in_wrap = int'(in_sensor);
    for (int k = 0; k < (1 << SENSOR_W) - 1; k++) begin
      if (in_wrap >= SENSORS) begin
        in_wrap = in_wrap - SENSORS;
      end
    end
  end

  assign in_base = AW'(in_wrap * POINTS);

  assign s_tready = (state == S_IDLE);

  always_comb begin
    load_diff = DIFF_W'(in_ref) - DIFF_W'(in_off);
    if (load_diff > DIFF_W'(32767)) begin
      load_meas = 16'sh7fff;
    end else if (load_diff < -DIFF_W'(32768)) begin
      load_meas = -16'sh8000;
    end else begin
      load_meas = load_diff[TEMP_W-1:0];
    end
  end

  assign wr_en   = s_tvalid && s_tready && (s_tuser == FN_LOAD) && (32'(in_point) < POINTS);
  assign wr_addr = in_base + AW'(in_point);

  always_comb begin
    case (state)
      S_ADDR:  rd_addr = base + AW'(idx);
      S_RDB:   rd_addr = base + AW'(top) - AW'(1);
      S_RDT:   rd_addr = base + AW'(top);
      default: rd_addr = base;
    endcase
  end

  plc_table #(.DEPTH(DEPTH), .AW(AW)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({load_meas, in_off}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_meas = rd_data[WORD_W-1:TEMP_W];
  assign rd_off  = rd_data[TEMP_W-1:0];

  assign num_mag   = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
  assign dm_mag    = dm[DIFF_W-1] ? -dm : dm;
  assign div_numer = num_mag[DIVN_W-1:0];
  assign div_denom = dm_mag[DIVD_W-1:0];
  assign div_start = (state == S_START);

  plc_divider #(.NW(DIVN_W), .DW(DIVD_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .quot  (div_quot),
    .done  (div_done)
  );

  always_comb begin
    q_s = $signed(SUM_W'(div_quot));
    if (neg) begin
      q_s = -q_s;
    end
    sum = q_s + SUM_W'(raw) + SUM_W'(ob);
    if (flat) begin
      cal_val    = raw;
      cal_status = ST_FLAT;
    end else if (sum > SUM_W'(32767)) begin
      cal_val    = 16'sh7fff;
      cal_status = ST_SAT;
    end else if (sum < -SUM_W'(32768)) begin
      cal_val    = -16'sh8000;
      cal_status = ST_SAT;
    end else begin
      cal_val    = sum[TEMP_W-1:0];
      cal_status = ST_OK;
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign found    = !(rd_meas < raw) || (idx == IW'(POINTS - 1));
  assign out_load = (state == S_FIN) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (s_tvalid && s_tuser == FN_CAL) state_next = S_ADDR;
      S_ADDR:  state_next = S_CMP;
      S_CMP:   state_next = found ? S_RDB : S_ADDR;
      S_RDB:   state_next = S_RDT;
      S_RDT:   state_next = S_DIFF;
      S_DIFF:  state_next = S_MUL;
      S_MUL:   state_next = (dm == '0) ? S_FIN : S_START;
      S_START: state_next = S_DIV;
      S_DIV:   if (div_done) state_next = S_FIN;
      S_FIN:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        idx  <= '0;
        base <= in_base;
        raw  <= in_raw;
        sens <= in_sensor;
      end
      S_CMP: begin
        if (found) begin
          top <= (idx == '0) ? IW'(1) : idx;
        end else begin
          idx <= idx + IW'(1);
        end
      end
      S_DIFF: begin
        dm  <= DIFF_W'(rd_meas) - DIFF_W'(mb);
        dof <= DIFF_W'(rd_off) - DIFF_W'(ob);
        dr  <= DIFF_W'(raw) - DIFF_W'(mb);
      end
      S_MUL: begin
        num  <= dr * dof;
        flat <= (dm == '0);
        neg  <= dr[DIFF_W-1] ^ dof[DIFF_W-1] ^ dm[DIFF_W-1];
      end
      default: begin
      end
    endcase
    if (state == S_RDT) begin
      mb <= rd_meas;
      ob <= rd_off;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cal    <= cal_val;
      out_sens   <= sens;
      out_status <= cal_status;
    end
  end

  assign m_tdata = {(OUT_DATA_W - TEMP_W - SENSOR_W)'(0), out_sens, out_cal};
  assign m_tuser = out_status;

  `PLC_ASSERT_NOW(a_div_done_in_div, div_done, state == S_DIV)
  `PLC_ASSERT_NEXT(a_cal_starts_search, s_tvalid && s_tready && s_tuser == FN_CAL,
                   state == S_ADDR && idx == '0)
  `PLC_ASSERT_NEXT(a_result_posted, out_load, m_tvalid && state == S_IDLE)

endmodule

[tb/tb_piecewise_linear_temp_calibrator.sv]
// Self-checking testbench for the piecewise linear temperature calibrator.
`timescale 1ns / 100ps

module tb_piecewise_linear_temp_calibrator;
  import plc_pkg::*;

  localparam int POINTS       = 8;
  localparam int SENSORS      = 4;
  localparam int DIR_ROWS     = 25;
  localparam int RAND_ITEMS   = 1400;
  localparam int TOTAL_ITEMS  = DIR_ROWS + RAND_ITEMS;
  localparam int TAIL_ITEMS   = 150;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 400;
  localparam int PAUSE_AT     = 900;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct packed {
    func_t      fn;
    logic [1:0] sens;
    logic [2:0] pt;
    temp_t      ref_temp;
    temp_t      offs;
    temp_t      raw;
    logic       has_exp;
    temp_t      exp_cal;
    status_t    exp_st;
  } stim_row_t;

  typedef struct packed {
    temp_t      cal;
    logic [1:0] sens;
    status_t    st;
  } cal_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;

  temp_t             meas_tbl [SENSORS][POINTS];
  temp_t             offs_tbl [SENSORS][POINTS];
  logic [POINTS-1:0] loaded [SENSORS] = '{default: '0};
  cal_result_t       pending_results [$];
  stim_row_t         dir_tbl [DIR_ROWS];

  int          items_sent = 0;
  int          errors = 0;
  int unsigned cycles = 0;
  logic        idle_on = 1'b1;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;
  int          stall_left = 0;

  piecewise_linear_temp_calibrator #(
    .POINTS (POINTS),
    .SENSORS(SENSORS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void store_breakpoint(input logic [1:0] sens, input logic [2:0] pt,
                                           input temp_t ref_temp, input temp_t offs);
    int diff;
    diff = int'(ref_temp) - int'(offs);
    if (diff > 32767) diff = 32767;
    else if (diff < -32768) diff = -32768;
    meas_tbl[sens][pt] = temp_t'(diff);
    offs_tbl[sens][pt] = offs;
    loaded[sens][pt]   = 1'b1;
  endfunction

  function automatic cal_result_t predict_calibration(input logic [1:0] sens, input temp_t raw);
    cal_result_t res;
    int          top;
    bit          found;
    longint      mb, mt, ob, ot, sum;
    top   = POINTS - 1;
    found = 1'b0;
    for (int i = 0; i < POINTS; i++) begin
      if (!found && !(meas_tbl[sens][i] < raw)) begin
        top   = i;
        found = 1'b1;
      end
    end
    if (top < 1) top = 1;
    mb = meas_tbl[sens][top-1];
    mt = meas_tbl[sens][top];
    ob = offs_tbl[sens][top-1];
    ot = offs_tbl[sens][top];
    res.sens = sens;
    if (mt == mb) begin
      res.cal = raw;
      res.st  = ST_FLAT;
    end else begin
      // product first, then divide truncating toward zero
      sum = longint'(raw) + ((longint'(raw) - mb) * (ot - ob)) / (mt - mb) + ob;
      if (sum > 32767) begin
        res.cal = 16'sh7fff;
        res.st  = ST_SAT;
      end else if (sum < -32768) begin
        res.cal = 16'sh8000;
        res.st  = ST_SAT;
      end else begin
        res.cal = temp_t'(sum);
        res.st  = ST_OK;
      end
    end
    return res;
  endfunction

  function automatic stim_row_t mk_row(input func_t fn, input int sens, input int pt,
                                       input int ref_temp, input int offs, input int raw,
                                       input bit has_exp = 1'b0, input int exp_cal = 0,
                                       input status_t exp_st = ST_OK);
    stim_row_t r;
    r.fn       = fn;
    r.sens     = 2'(sens);
    r.pt       = 3'(pt);
    r.ref_temp = temp_t'(ref_temp);
    r.offs     = temp_t'(offs);
    r.raw      = temp_t'(raw);
    r.has_exp  = has_exp;
    r.exp_cal  = temp_t'(exp_cal);
    r.exp_st   = exp_st;
    return r;
  endfunction

  task automatic send_word(input stim_row_t row);
    cal_result_t res;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= row.fn;
    s_tdata  <= {3'b000, row.raw, row.offs, row.ref_temp, row.pt, row.sens};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (row.fn == FN_LOAD) begin
      store_breakpoint(row.sens, row.pt, row.ref_temp, row.offs);
    end else begin
      res = predict_calibration(row.sens, row.raw);
      if (row.has_exp) begin
        res.cal = row.exp_cal;
        res.st  = row.exp_st;
      end
      pending_results.push_back(res);
    end
  endtask

  // ascending curve with random spacing and offsets; zero steps make flat segments
  task automatic load_ascending_table(input logic [1:0] sens);
    int lvl [POINTS];
    int step_max, level, span, p, o, r;
    bit reverse;
    step_max = ($urandom_range(0, 3) == 0) ? 8000 : int'($urandom_range(1, 600));
    level    = int'($urandom_range(0, 65535)) - 32768;
    if (level > 32767 - 7 * step_max) level = 32767 - 7 * step_max;
    span     = ($urandom_range(0, 3) == 0) ? 32767 : int'($urandom_range(0, 1024));
    reverse  = $urandom_range(0, 1);
    for (int k = 0; k < POINTS; k++) begin
      lvl[k] = level;
      if ($urandom_range(0, 7) != 0) level += int'($urandom_range(1, step_max));
    end
    for (int k = 0; k < POINTS; k++) begin
      p = reverse ? POINTS - 1 - k : k;
      o = int'($urandom_range(0, 2 * span)) - span;
      r = lvl[p] + o;
      if (r > 32767) r = 32767;
      else if (r < -32768) r = -32768;
      send_word(mk_row(FN_LOAD, sens, p, r, o, int'($urandom)));
    end
  endtask

  function automatic temp_t pick_raw(input logic [1:0] sens);
    int lo, hi, v;
    case ($urandom_range(0, 9))
      0, 1, 2: return temp_t'($urandom);
      3, 4: begin
        v = int'(meas_tbl[sens][$urandom_range(0, POINTS - 1)]) + int'($urandom_range(0, 2)) - 1;
        return temp_t'(v);
      end
      default: begin
        lo = meas_tbl[sens][0];
        hi = meas_tbl[sens][POINTS-1];
        if (lo > hi) begin
          v  = lo;
          lo = hi;
          hi = v;
        end
        lo -= 300;
        hi += 300;
        v = lo + int'($urandom_range(0, hi - lo));
        if (v > 32767) v = 32767;
        else if (v < -32768) v = -32768;
        return temp_t'(v);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      m_tready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 2);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cal_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no calibration pending: %h / %h", m_tdata, m_tuser);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[15:0] !== want.cal) begin
          $error("calibrated_temp: expected %0d, got %0d", want.cal, $signed(m_tdata[15:0]));
          errors++;
        end
        if (m_tdata[17:16] !== want.sens) begin
          $error("sensor_echo: expected %0d, got %0d", want.sens, m_tdata[17:16]);
          errors++;
        end
        if (m_tuser !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, m_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    logic [1:0] sens;
    int  next_flip;
    int  pick;
    bit  paused;
    // sensor 0: saturated end points, flat first segment, fractional slopes
    dir_tbl[0]  = mk_row(FN_LOAD, 0, 0, -32768, 32767, 0);
    dir_tbl[1]  = mk_row(FN_LOAD, 0, 1, -32768, 0, 0);
    dir_tbl[2]  = mk_row(FN_LOAD, 0, 2, 0, 0, 0);
    dir_tbl[3]  = mk_row(FN_LOAD, 0, 3, 512, 256, 0);
    dir_tbl[4]  = mk_row(FN_LOAD, 0, 4, 512, 0, 0);
    dir_tbl[5]  = mk_row(FN_LOAD, 0, 5, 1024, 0, 0);
    dir_tbl[6]  = mk_row(FN_LOAD, 0, 6, 2053, 5, 0);
    dir_tbl[7]  = mk_row(FN_LOAD, 0, 7, 32767, -32768, 0);
    // sensor 1: unit slope, used for extrapolation into saturation
    dir_tbl[8]  = mk_row(FN_LOAD, 1, 0, 0, 0, 0);
    dir_tbl[9]  = mk_row(FN_LOAD, 1, 1, 512, 256, 0);
    dir_tbl[10] = mk_row(FN_LOAD, 1, 2, 1024, 512, 0);
    dir_tbl[11] = mk_row(FN_LOAD, 1, 3, 1536, 768, 0);
    dir_tbl[12] = mk_row(FN_LOAD, 1, 4, 2048, 1024, 0);
    dir_tbl[13] = mk_row(FN_LOAD, 1, 5, 2560, 1280, 0);
    dir_tbl[14] = mk_row(FN_LOAD, 1, 6, 3072, 1536, 0);
    dir_tbl[15] = mk_row(FN_LOAD, 1, 7, 3584, 1792, 0);
    dir_tbl[16] = mk_row(FN_CAL, 0, 0, 0, 0, -32768, 1'b1, -32768, ST_FLAT);
    dir_tbl[17] = mk_row(FN_CAL, 0, 0, 0, 0, 0);
    dir_tbl[18] = mk_row(FN_CAL, 0, 0, 0, 0, 128);
    dir_tbl[19] = mk_row(FN_CAL, 0, 0, 0, 0, 1500);
    dir_tbl[20] = mk_row(FN_CAL, 0, 0, 0, 0, 3000);
    dir_tbl[21] = mk_row(FN_CAL, 0, 0, 0, 0, 32767);
    dir_tbl[22] = mk_row(FN_CAL, 1, 0, 0, 0, 32767, 1'b1, 32767, ST_SAT);
    dir_tbl[23] = mk_row(FN_CAL, 1, 0, 0, 0, -32768, 1'b1, -32768, ST_SAT);
    dir_tbl[24] = mk_row(FN_CAL, 1, 0, 0, 0, 100);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) send_word(dir_tbl[i]);

    next_flip = items_sent + 100;
    paused    = 1'b0;
    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= TOTAL_ITEMS - TAIL_ITEMS) begin
        idle_on <= 1'b0;
      end else if (items_sent >= next_flip) begin
        idle_on   <= ($urandom_range(0, 3) != 0);
        next_flip += 100;
      end
      if (items_sent >= HOLD_AT) hold_req <= 1'b1;
      if (!paused && items_sent >= PAUSE_AT) begin
        paused = 1'b1;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      sens = 2'($urandom_range(0, SENSORS - 1));
      pick = int'($urandom_range(0, 99));
      if (pick <= 5) begin
        load_ascending_table(sens);
      end else if (pick <= 13) begin
        send_word(mk_row(FN_LOAD, sens, $urandom_range(0, POINTS - 1),
                         int'($urandom), int'($urandom), int'($urandom)));
      end else begin
        if (&loaded[sens]) begin
          row = mk_row(FN_CAL, sens, $urandom_range(0, POINTS - 1),
                       int'($urandom), int'($urandom), 0);
          row.raw = pick_raw(sens);
          send_word(row);
        end else begin
          load_ascending_table(sens);
        end
      end
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
